// ===== rtl/ksc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ksc_pkg;

   // alphabet and key geometry
   localparam int KEY_LEN   = 5;
   localparam int ALPHA_LEN = 26;
   localparam int COUNT_W   = $clog2(KEY_LEN + 1);

   typedef logic [4:0]         letter_type;
   typedef logic [7:0]         char_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [4:0]         csr_data_type;

   localparam letter_type LETTER_MAX = letter_type'(ALPHA_LEN - 1);
   // highest rank of a non-key letter that still finds a place in the cipher alphabet
   localparam letter_type TAIL_RANK_MAX = letter_type'(ALPHA_LEN - KEY_LEN - 1);

   // ascii landmarks
   localparam char_type ASCII_UPPER_A = 8'd65;
   localparam char_type ASCII_UPPER_Z = 8'd90;
   localparam char_type ASCII_LOWER_A = 8'd97;
   localparam char_type ASCII_LOWER_Z = 8'd122;
   localparam char_type CASE_OFFSET   = 8'd32;

   // register indexes
   localparam csr_index_type CSR_KEY_FIRST  = 3'd0;
   localparam csr_index_type CSR_KEY_SECOND = 3'd1;
   localparam csr_index_type CSR_KEY_THIRD  = 3'd2;
   localparam csr_index_type CSR_KEY_FOURTH = 3'd3;
   localparam csr_index_type CSR_KEY_FIFTH  = 3'd4;
   localparam csr_index_type CSR_DIRECTION  = 3'd5;

   // direction codes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/keyword_substitution_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keyword substitution cipher, one ASCII character per transaction. The cipher
// alphabet is the five key letters (csr registers 0..4, a=0, values above 25 read
// as z) followed by the remaining letters in alphabetical order; register 5
// selects encrypt (0) or decrypt (1). Uppercase letters come back lowercase,
// anything that is not a letter comes back unchanged, and rsp_key_repeated flags
// a key that holds the same letter twice. With a repeated key the alphabetically
// last letters fall off the cipher alphabet; decrypting such a letter returns it
// as is, and a letter present twice decrypts to its first position. The block
// takes one character every clock cycle unless rsp_stall holds it back; each
// character passes the input register and then the result register, with the
// whole mapping worked out in the logic between them. The result register lets
// a new transaction in while a finished one waits on rsp_stall. Change the key
// or the direction only while no transaction is in flight.

module keyword_substitution_cipher (
   input  wire                     clock,
   input  wire                     reset,
   // configuration writes
   input  wire                     csr_wr_en,
   input  wire ksc_pkg::csr_index_type csr_index,
   input  wire ksc_pkg::csr_data_type  csr_wr_data,
   // request channel
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire ksc_pkg::char_type  req_char_in,
   // response channel
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output ksc_pkg::char_type       rsp_char_out,
   output logic                    rsp_key_repeated
);

   import ksc_pkg::*;

   // configuration registers
   letter_type key_ff [KEY_LEN];
   logic       dir_ff;

   // key analysis, derived from the registers alone
   letter_type           key_sat   [KEY_LEN];
   logic [KEY_LEN-1:0]   key_first;
   count_type            below_cnt [KEY_LEN];
   letter_type           key_gap   [KEY_LEN];
   logic                 key_rep;

   // input stage
   logic     s1_valid_ff;
   char_type s1_char_ff;
   logic     s1_load_en;
   logic     s1_move;
   logic     out_ready;

   // mapping logic
   char_type   s1_lower;
   logic       s1_is_letter;
   letter_type letter_idx;
   letter_type tail_q;
   count_type  tail_add;
   letter_type enc_letter;
   logic       dec_hit;
   letter_type dec_pos;
   count_type  dec_below;
   letter_type dec_rank;
   letter_type dec_letter;
   letter_type map_letter;
   char_type   rsp_char_in;

   // result stage
   logic     rsp_valid_ff;
   char_type rsp_char_ff;
   logic     rsp_rep_ff;

   // ---------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_LEN; i++) begin
            key_ff[i] <= letter_type'(i);
         end
         dir_ff <= MODE_ENCRYPT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_FIRST:  key_ff[0] <= csr_wr_data;
            CSR_KEY_SECOND: key_ff[1] <= csr_wr_data;
            CSR_KEY_THIRD:  key_ff[2] <= csr_wr_data;
            CSR_KEY_FOURTH: key_ff[3] <= csr_wr_data;
            CSR_KEY_FIFTH:  key_ff[4] <= csr_wr_data;
            CSR_DIRECTION:  dir_ff    <= csr_wr_data[0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // key analysis
   // key_first marks the first occurrence of each distinct letter; key_gap is
   // the number of non-key letters below that key letter, so the tail rank q
   // lands on letter q plus the count of distinct keys whose gap is <= q
   // ---------------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < KEY_LEN; i++) begin
         key_sat[i] = (key_ff[i] > LETTER_MAX) ? LETTER_MAX : key_ff[i];
      end
      for (int i = 0; i < KEY_LEN; i++) begin
         key_first[i] = 1'b1;
         for (int j = 0; j < i; j++) begin
            if (key_sat[j] == key_sat[i]) begin
               key_first[i] = 1'b0;
            end
         end
      end
      key_rep = ~(&key_first);
      for (int i = 0; i < KEY_LEN; i++) begin
         below_cnt[i] = '0;
         for (int j = 0; j < KEY_LEN; j++) begin
            if (key_first[j] && (key_sat[j] < key_sat[i])) begin
               below_cnt[i] = below_cnt[i] + count_type'(1);
            end
         end
         key_gap[i] = key_sat[i] - letter_type'(below_cnt[i]);
      end
   end

   // ---------------------------------------------------------------------------
   // flow control: input register feeds the result register
   // ---------------------------------------------------------------------------
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_ready;
   assign s1_load_en = !s1_valid_ff || s1_move;
   assign req_stall  = !s1_load_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_load_en) begin
         s1_char_ff <= req_char_in;
      end
   end

   // ---------------------------------------------------------------------------
   // character mapping
   // ---------------------------------------------------------------------------
   always_comb begin
      // fold uppercase onto lowercase
      if ((s1_char_ff >= ASCII_UPPER_A) && (s1_char_ff <= ASCII_UPPER_Z)) begin
         s1_lower = s1_char_ff + CASE_OFFSET;
      end else begin
         s1_lower = s1_char_ff;
      end
      s1_is_letter = (s1_lower >= ASCII_LOWER_A) && (s1_lower <= ASCII_LOWER_Z);
      letter_idx   = letter_type'(s1_lower - ASCII_LOWER_A);

      // encrypt: head positions are the key letters, tail positions walk the
      // non-key letters
      tail_q   = letter_idx - letter_type'(KEY_LEN);
      tail_add = '0;
      for (int i = 0; i < KEY_LEN; i++) begin
         if (key_first[i] && (key_gap[i] <= tail_q)) begin
            tail_add = tail_add + count_type'(1);
         end
      end
      enc_letter = tail_q + letter_type'(tail_add);
      for (int i = 0; i < KEY_LEN; i++) begin
         if (letter_idx == letter_type'(i)) begin
            enc_letter = key_sat[i];
         end
      end

      // decrypt: a key letter goes to its first key position, any other letter
      // to the tail by its rank among non-key letters
      dec_hit = 1'b0;
      dec_pos = '0;
      for (int i = KEY_LEN - 1; i >= 0; i--) begin
         if (key_sat[i] == letter_idx) begin
            dec_hit = 1'b1;
            dec_pos = letter_type'(i);
         end
      end
      dec_below = '0;
      for (int i = 0; i < KEY_LEN; i++) begin
         if (key_first[i] && (key_sat[i] < letter_idx)) begin
            dec_below = dec_below + count_type'(1);
         end
      end
      dec_rank = letter_idx - letter_type'(dec_below);
      if (dec_hit) begin
         dec_letter = dec_pos;
      end else if (dec_rank <= TAIL_RANK_MAX) begin
         dec_letter = dec_rank + letter_type'(KEY_LEN);
      end else begin
         // dropped from the cipher alphabet by a repeated key
         dec_letter = letter_idx;
      end

      map_letter = (dir_ff == MODE_DECRYPT) ? dec_letter : enc_letter;

      if (s1_is_letter) begin
         rsp_char_in = ASCII_LOWER_A + char_type'(map_letter);
      end else begin
         rsp_char_in = s1_lower;
      end
   end

   // ---------------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_char_ff <= rsp_char_in;
         rsp_rep_ff  <= key_rep;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_key_repeated = rsp_rep_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   a_s1_holds_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff)
      else $error("input stage lost a blocked transaction");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");

   a_move_fills_result: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("transaction moved but result register empty");

   a_letter_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_is_letter |-> (map_letter <= LETTER_MAX))
      else $error("mapped letter outside the alphabet");

   a_no_uppercase_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !((rsp_char_ff >= ASCII_UPPER_A) && (rsp_char_ff <= ASCII_UPPER_Z)))
      else $error("uppercase letter on the response");

endmodule

`default_nettype wire
